// ----- src/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, prop)

`endif

`endif

// ----- src/suks_pkg.sv -----
package suks_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KEY_BITS_DEF = 32;
	localparam int MODE_W       = 2;
	localparam int KEY_W        = 32;
	localparam int ENTRIES_W    = 7;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 2'd0,
		MODE_LOOKUP = 2'd1,
		MODE_CLEAR  = 2'd2
	} mode_t;

	// control into one cell
	typedef struct packed {
		logic valid;
		logic wr;
		logic left_lt;
	} cell_ctl_t;

	// compare status out of one cell
	typedef struct packed {
		logic lt;
		logic eq;
	} cell_stat_t;

endpackage

// ----- src/suks_if.sv -----
interface suks_in_if import suks_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [KEY_W-1:0]  key;

	modport source (output valid, output mode, output key, input ready);
	modport sink (input valid, input mode, input key, output ready);
endinterface

interface suks_out_if import suks_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 present;
	logic                 added;
	logic                 full_res;
	logic [ENTRIES_W-1:0] entries;

	modport source (output valid, output present, output added, output full_res,
		output entries, input ready);
	modport sink (input valid, input present, input added, input full_res,
		input entries, output ready);
endinterface

// ----- src/sorted_unique_key_set.sv -----
// channel   dir  fields                             handshake
// items     in   mode, key                          valid / ready
// results   out  present, added, full_res, entries  valid / ready
//
// one word per cycle while results are taken: every cell compares its key with the incoming key and
// the insert shifts the upper cells right by one in the same cycle
// the result sits in an output register; items stay ready while it is empty
// or being taken, so a stalled results side holds off the next word
// reset clears the key count and the result valid flag, the cell keys need no clearing pass
`include "assert_macros.svh"

module sorted_unique_key_set import suks_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	suks_in_if.sink     items,
	suks_out_if.source  results
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_d;
	logic [KEY_BITS-1:0] k;
	logic                acc;
	logic                hit;
	logic                full;
	logic                wr;
	logic                added_d;
	logic                full_d;
	logic                present_d;

	logic                 out_valid_q;
	logic                 present_q;
	logic                 added_q;
	logic                 full_q;
	logic [ENTRIES_W-1:0] entries_q;

	cell_ctl_t           ctl  [CAPACITY];
	cell_stat_t          stat [CAPACITY];
	logic [KEY_BITS-1:0] keys [CAPACITY];
	logic [CAPACITY-1:0] eq_vec;

	assign k   = KEY_BITS'(items.key);
	assign acc = items.valid && items.ready;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign ctl[i].valid   = CNT_W'(i) < count_q;
		assign ctl[i].wr      = wr;
		assign ctl[i].left_lt = (i == 0) ? 1'b1 : stat[(i == 0) ? 0 : i-1].lt;
		assign eq_vec[i]      = stat[i].eq;

		suks_cell #(.KEY_BITS(KEY_BITS)) u_cell (
			.clk      (clk),
			.ctl      (ctl[i]),
			.k        (k),
			.left_key (keys[(i == 0) ? 0 : i-1]),
			.stat     (stat[i]),
			.key_q    (keys[i])
		);
	end

	assign hit  = |eq_vec;
	assign full = count_q == CNT_W'(CAPACITY);

	always_comb begin
		count_d   = count_q;
		wr        = 1'b0;
		added_d   = 1'b0;
		full_d    = 1'b0;
		present_d = 1'b0;
		case (mode_t'(items.mode))
			MODE_INSERT: begin
				present_d = hit;
				if (!hit) begin
					if (full) begin
						full_d = 1'b1;
					end else begin
						wr      = acc;
						added_d = 1'b1;
						count_d = count_q + 1'b1;
					end
				end
			end
			MODE_LOOKUP: begin
				present_d = hit;
			end
			MODE_CLEAR: begin
				count_d = '0;
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	assign items.ready = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			present_q <= present_d;
			added_q   <= added_d;
			full_q    <= full_d;
			entries_q <= ENTRIES_W'(count_d);
		end
	end

	assign results.valid    = out_valid_q;
	assign results.present  = present_q;
	assign results.added    = added_q;
	assign results.full_res = full_q;
	assign results.entries  = entries_q;

	`ASSERT_NEVER(a_count_range, clk, arst_n, count_q > CNT_W'(CAPACITY))
	`ASSERT_HOLDS(a_insert_grows, clk, arst_n, wr |=> count_q == $past(count_q) + 1'b1)
	`ASSERT_NEVER(a_added_and_full, clk, arst_n, out_valid_q && added_q && full_q)
	`ASSERT_HOLDS(a_no_write_on_hit, clk, arst_n, hit |-> !wr)

	for (genvar i = 1; i < CAPACITY; i++) begin : g_chk
		`ASSERT_HOLDS(a_sorted, clk, arst_n, ctl[i].valid |-> keys[i-1] < keys[i])
	end

endmodule

// ----- src/suks_cell.sv -----
module suks_cell import suks_pkg::*; #(
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic                clk,
	input  cell_ctl_t           ctl,
	input  logic [KEY_BITS-1:0] k,
	input  logic [KEY_BITS-1:0] left_key,
	output cell_stat_t          stat,
	output logic [KEY_BITS-1:0] key_q
);

	always_comb begin
		stat.lt = ctl.valid && (key_q < k);
		stat.eq = ctl.valid && (key_q == k);
	end

	// on an insert: keep if below the new key, take the new key at the insert point, else shift right
	always_ff @(posedge clk) begin
		if (ctl.wr && !stat.lt) begin
			if (ctl.left_lt) begin
				key_q <= k;
			end else begin
				key_q <= left_key;
			end
		end
	end

endmodule
